// ===== sv/dpq_pkg.sv =====
// dpq_pkg: shared types and constants for the double-ended priority queue
// no dependencies; used by dpq_mem, dpq_ctrl and double_ended_priority_queue
package dpq_pkg;

    localparam int unsigned DEF_CAPACITY = 1024;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned LIVE_W       = 11;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_LAST,
        S_FIX_RD,
        S_FIX_WAIT,
        S_FINISH
    } state_t;

    // one result transaction as handed from the controller to the output stage
    typedef struct packed {
        status_t                   status;
        logic                      is_empty;
        logic [LIVE_W-1:0]         live_count;
        logic signed [VAL_W-1:0]   max_value;
        logic signed [VAL_W-1:0]   min_value;
    } res_t;

endpackage

// ===== sv/dpq_mem.sv =====
// dpq_mem: simple dual-port entry memory, one write and one registered read port
// depends on dpq_pkg for the value width
module dpq_mem #(
    parameter int unsigned DEPTH = dpq_pkg::DEF_CAPACITY,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [dpq_pkg::VAL_W-1:0]  wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic signed [dpq_pkg::VAL_W-1:0]  rd_data
);
    import dpq_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dpq_ctrl.sv =====
// dpq_ctrl: sequencer keeping the entries sorted in a circular buffer of dpq_mem
// depends on dpq_pkg and dpq_mem
module dpq_ctrl #(
    parameter int unsigned CAPACITY = dpq_pkg::DEF_CAPACITY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_operation,
    input  logic signed [dpq_pkg::VAL_W-1:0]  in_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output dpq_pkg::res_t                     res
);
    import dpq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned KW = AW + 1;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next, in_op;
    status_t                 status_reg, status_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic signed [VAL_W-1:0] max_reg, max_next;
    logic signed [VAL_W-1:0] min_reg, min_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [KW-1:0]           k_reg, k_next;

    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic signed [VAL_W-1:0] wr_data, rd_data;
    logic                    is_full, is_zero, shift_up;

    // slot of sorted position k, wrapping round the end of the buffer
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [KW-1:0] k);
        logic [KW-1:0] sum;
        sum = {1'b0, head} + k;
        if (sum >= KW'(CAPACITY)) begin
            sum = sum - KW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    dpq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_op    = op_t'(in_operation);
    assign is_full  = (cnt_reg == CW'(CAPACITY));
    assign is_zero  = (cnt_reg == '0);
    assign shift_up = (rd_data > val_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    unique case (in_op)
                        OP_INSERT: begin
                            state_next = (is_full || is_zero) ? S_FINISH : S_INS_RD;
                        end
                        OP_DEL_MAX, OP_DEL_MIN: begin
                            state_next = (cnt_reg <= CW'(1)) ? S_FINISH : S_FIX_RD;
                        end
                        OP_CLEAR: state_next = S_FINISH;
                    endcase
                end
            end
            S_INS_RD:  state_next = S_INS_CMP;
            S_INS_CMP: begin
                if (!shift_up) begin
                    state_next = S_FINISH;
                end else if (k_reg == '0) begin
                    state_next = S_INS_LAST;
                end
            end
            S_INS_LAST: state_next = S_FINISH;
            S_FIX_RD:   state_next = S_FIX_WAIT;
            S_FIX_WAIT: state_next = S_FINISH;
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = val_reg;
        rd_en   = 1'b0;
        rd_addr = slot(head_reg, k_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_op == OP_INSERT && is_zero) begin
                    wr_en   = 1'b1;
                    wr_data = in_value;
                end
            end
            S_INS_RD: rd_en = 1'b1;
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, k_reg + KW'(1));
                if (shift_up) begin
                    wr_data = rd_data;
                    if (k_reg != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = slot(head_reg, k_reg - KW'(1));
                    end
                end
            end
            S_INS_LAST: wr_en = 1'b1;
            S_FIX_RD:   rd_en = 1'b1;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        op_next     = op_reg;
        val_next    = val_reg;
        status_next = status_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    val_next    = in_value;
                    status_next = ST_DONE;
                    unique case (in_op)
                        OP_INSERT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else if (is_zero) begin
                                cnt_next = CW'(1);
                                max_next = in_value;
                                min_next = in_value;
                            end else begin
                                max_next = (in_value > max_reg) ? in_value : max_reg;
                                min_next = (in_value < min_reg) ? in_value : min_reg;
                                k_next   = KW'(cnt_reg - CW'(1));
                            end
                        end
                        OP_DEL_MAX: begin
                            if (is_zero) begin
                                status_next = ST_EMPTY;
                            end else begin
                                cnt_next = cnt_reg - CW'(1);
                                k_next   = KW'(cnt_reg - CW'(2));
                            end
                        end
                        OP_DEL_MIN: begin
                            if (is_zero) begin
                                status_next = ST_EMPTY;
                            end else begin
                                cnt_next  = cnt_reg - CW'(1);
                                head_next = slot(head_reg, KW'(1));
                                k_next    = '0;
                            end
                        end
                        OP_CLEAR: cnt_next = '0;
                    endcase
                end
            end
            S_INS_CMP: begin
                if (!shift_up) begin
                    cnt_next = cnt_reg + CW'(1);
                end else if (k_reg != '0) begin
                    k_next = k_reg - KW'(1);
                end
            end
            S_INS_LAST: cnt_next = cnt_reg + CW'(1);
            S_FIX_WAIT: begin
                if (op_reg == OP_DEL_MAX) begin
                    max_next = rd_data;
                end else begin
                    min_next = rd_data;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        max_reg    <= max_next;
        min_reg    <= min_next;
        k_reg      <= k_next;
    end

    // handshake and result
    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_FINISH);
    assign res.status     = status_reg;
    assign res.is_empty   = is_zero;
    assign res.live_count = LIVE_W'(cnt_reg);
    assign res.max_value  = is_zero ? '0 : max_reg;
    assign res.min_value  = is_zero ? '0 : min_reg;

endmodule

// ===== sv/double_ended_priority_queue.sv =====
// double_ended_priority_queue: top level with output register and checks
// depends on dpq_pkg and dpq_ctrl
//
//   channel  | ports                                    | direction
//   s_       | s_valid s_ready s_operation s_value      | in
//   m_       | m_valid m_ready m_status m_is_empty      | out
//            | m_live_count m_max_value m_min_value     |
//
// insert: shifts up each stored entry larger than the new value, walked through
// the single memory read port; on an empty or full queue it finishes at once;
// delete: reads the new extreme unless at most one entry remains; clear: resets
// the count only. Reset is immediate, no memory clearing pass. A waiting result
// sits in the output register while the next transaction is taken; the controller
// holds its finished result until that register frees.
module double_ended_priority_queue #(
    parameter int unsigned CAPACITY = dpq_pkg::DEF_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic signed [dpq_pkg::VAL_W-1:0]    s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic                                m_is_empty,
    output logic [dpq_pkg::LIVE_W-1:0]          m_live_count,
    output logic signed [dpq_pkg::VAL_W-1:0]    m_max_value,
    output logic signed [dpq_pkg::VAL_W-1:0]    m_min_value
);
    import dpq_pkg::*;

    logic res_valid, res_ready;
    res_t res;
    res_t out_reg;
    logic m_valid_reg;

    dpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_operation (s_operation),
        .in_value     (s_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_is_empty   = out_reg.is_empty;
    assign m_live_count = out_reg.live_count;
    assign m_max_value  = out_reg.max_value;
    assign m_min_value  = out_reg.min_value;

`ifndef SYNTHESIS
    // the controller is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // empty queue reports zero extremes
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_max_value == '0 && m_min_value == '0)
        else $error("non-zero extremes on empty queue");

    // largest never below smallest
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_empty |-> m_max_value >= m_min_value)
        else $error("maximum below minimum");
`endif

endmodule
